### hdl/bms_status_frame_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// Status frame parser assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef BMS_STATUS_FRAME_PARSER_UNIT_MACROS_SVH
`define BMS_STATUS_FRAME_PARSER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define BSFP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsfp assertion failed");
`define BSFP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsfp assertion failed");
`else
`define BSFP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BSFP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hdl/bsfp_pkg.sv
// ----------------------------------------------------------------------------
// Status frame parser package
// Types, field offsets and signature bytes shared by the parser files.
// ----------------------------------------------------------------------------
package bsfp_pkg;

   localparam int OFF_W = 9;

   localparam logic [7:0] SIG_BYTES [4] = '{8'h55, 8'hAA, 8'hEB, 8'h90};
   localparam logic [2:0] SIG_LEN = 3'd4;

   localparam logic [OFF_W-1:0] OFF_TYPE  = 9'd4;
   localparam logic [OFF_W-1:0] OFF_CELLS = 9'd6;
   localparam logic [OFF_W-1:0] OFF_PACKV = 9'h076;
   localparam logic [OFF_W-1:0] OFF_CURR  = 9'h07E;
   localparam logic [OFF_W-1:0] OFF_TEMP  = 9'h082;
   localparam logic [OFF_W-1:0] OFF_CAP   = 9'h092;

   localparam logic [7:0] FT_CELLS = 8'd2;

   typedef enum logic [2:0] {
      KIND_CELL  = 3'd0,
      KIND_PACKV = 3'd1,
      KIND_CURR  = 3'd2,
      KIND_TEMP  = 3'd3,
      KIND_CAP   = 3'd4,
      KIND_DONE  = 3'd5,
      KIND_TRUNC = 3'd6
   } kind_type;

   typedef struct packed {
      logic [2:0]       sync_count;
      logic             in_frame;
      logic [OFF_W-1:0] byte_offset;
      logic [7:0]       frame_type;
      logic [23:0]      low_bytes;
      logic             cells_active;
      logic [4:0]       cell_counter;
   } state_type;

   typedef struct packed {
      kind_type            kind;
      logic [4:0]          item_index;
      logic signed [31:0]  value;
      logic [7:0]          frame_kind;
   } result_type;

endpackage

### hdl/bsfp_channels.sv
// ----------------------------------------------------------------------------
// Status frame parser channels
// Valid/ready interfaces for the byte input and the decoded result output.
// ----------------------------------------------------------------------------
interface bsfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       buffer_end;

   modport source (output valid, data_byte, buffer_end, input ready);
   modport sink   (input valid, data_byte, buffer_end, output ready);
endinterface

interface bsfp_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic [4:0]         item_index;
   logic signed [31:0] value;
   logic [7:0]         frame_kind;

   modport source (output valid, kind, item_index, value, frame_kind, input ready);
   modport sink   (input valid, kind, item_index, value, frame_kind, output ready);
endinterface

### hdl/bms_status_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// Battery monitor status frame parser
// Finds signature-framed status frames in a link byte stream and emits the
// decoded cell, pack, current, temperature and capacity fields of cell frames.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  req_chan  in         data_byte[7:0], buffer_end
//  rsp_chan  out        kind[2:0], item_index[4:0], value[31:0], frame_kind[7:0]
//
//  One byte per cycle while the result is not stalled. A byte is held in the
//  input register and its result is registered in the result register; the
//  combinational decode between them sets the rate and the next frame state.
//  Synchronous active-high reset; the first byte is taken the cycle after.
//  A stalled result holds the decode; the input register still absorbs one byte.
// ----------------------------------------------------------------------------
`include "bms_status_frame_parser_unit_macros.svh"

module bms_status_frame_parser_unit
   import bsfp_pkg::*;
#(
   parameter int FRAME_LEN = 300,
   parameter int MAX_CELLS = 24
) (
   input  logic         clock,
   input  logic         reset,
   bsfp_req_if.sink     req_chan,
   bsfp_rsp_if.source   rsp_chan
);

   localparam state_type STATE_RESET = '{
      sync_count:   3'd0,
      in_frame:     1'b0,
      byte_offset:  '0,
      frame_type:   8'd0,
      low_bytes:    24'd0,
      cells_active: 1'b1,
      cell_counter: 5'd0
   };

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   state_type  state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type dec_res;
   logic       dec_emit;
   logic       advance;
   logic       req_take;

   bsfp_decoder #(
      .FRAME_LEN (FRAME_LEN),
      .MAX_CELLS (MAX_CELLS)
   ) u_decoder (
      .cur        (state_ff),
      .data_byte  (in_byte_ff),
      .buffer_end (in_end_ff),
      .nxt        (state_in),
      .emit       (dec_emit),
      .res        (dec_res)
   );

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !reset && (!in_valid_ff || advance);
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = dec_emit;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.data_byte;
         in_end_ff  <= req_chan.buffer_end;
      end
      if (advance && dec_emit) begin
         out_ff <= dec_res;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.kind       = out_ff.kind;
   assign rsp_chan.item_index = out_ff.item_index;
   assign rsp_chan.value      = out_ff.value;
   assign rsp_chan.frame_kind = out_ff.frame_kind;

   `BSFP_ASSERT_NXT(a_end_closes_frame, clock, reset,
      advance && dec_emit && (dec_res.kind == KIND_DONE || dec_res.kind == KIND_TRUNC),
      !state_ff.in_frame)
   `BSFP_ASSERT_IMP(a_offset_in_frame, clock, reset, state_ff.in_frame,
      state_ff.byte_offset >= OFF_TYPE && state_ff.byte_offset < OFF_W'(FRAME_LEN))
   `BSFP_ASSERT_IMP(a_sync_below_len, clock, reset, !state_ff.in_frame,
      state_ff.sync_count < SIG_LEN)
   `BSFP_ASSERT_IMP(a_cell_index_range, clock, reset,
      out_valid_ff && out_ff.kind == KIND_CELL, out_ff.item_index < 5'(MAX_CELLS))

endmodule

### hdl/bsfp_decoder.sv
// ----------------------------------------------------------------------------
// Status frame parser byte decoder
// Signature search, frame offset tracking and field decode for one byte.
// ----------------------------------------------------------------------------
module bsfp_decoder
   import bsfp_pkg::*;
#(
   parameter int FRAME_LEN = 300,
   parameter int MAX_CELLS = 24
) (
   input  state_type  cur,
   input  logic [7:0] data_byte,
   input  logic       buffer_end,
   output state_type  nxt,
   output logic       emit,
   output result_type res
);

   localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(FRAME_LEN - 1);
   localparam logic [OFF_W-1:0] CELL_END = OFF_W'(6 + 2 * MAX_CELLS);

   logic [2:0]       sc;
   logic [7:0]       ftype;
   logic [15:0]      w16;
   logic [31:0]      w32;
   logic [OFF_W-1:0] off;
   logic [OFF_W-1:0] temp_rel;

   assign off      = cur.byte_offset;
   assign w16      = {data_byte, cur.low_bytes[23:16]};
   assign w32      = {data_byte, cur.low_bytes};
   assign temp_rel = off - OFF_TEMP;

   always_comb begin
      nxt            = cur;
      emit           = 1'b0;
      sc             = cur.sync_count;
      ftype          = cur.frame_type;
      res.kind       = KIND_DONE;
      res.item_index = '0;
      res.value      = '0;
      res.frame_kind = cur.frame_type;
      if (!cur.in_frame) begin
         if (cur.sync_count < SIG_LEN && data_byte == SIG_BYTES[cur.sync_count[1:0]]) begin
            sc = cur.sync_count + 3'd1;
         end else begin
            sc = (data_byte == SIG_BYTES[0]) ? 3'd1 : 3'd0;
         end
         if (sc == SIG_LEN && !buffer_end) begin
            nxt.in_frame     = 1'b1;
            nxt.byte_offset  = OFF_TYPE;
            nxt.frame_type   = '0;
            nxt.low_bytes    = '0;
            nxt.cells_active = 1'b1;
            nxt.cell_counter = '0;
            sc               = 3'd0;
         end
         nxt.sync_count = buffer_end ? 3'd0 : sc;
      end else begin
         if (off == OFF_TYPE) begin
            ftype = data_byte;
         end
         nxt.frame_type = ftype;
         res.frame_kind = ftype;
         if (off >= LAST_OFF) begin
            emit     = 1'b1;
            res.kind = KIND_DONE;
         end else if (buffer_end) begin
            emit     = 1'b1;
            res.kind = KIND_TRUNC;
         end else if (ftype == FT_CELLS && off[0]) begin
            if (off >= OFF_CELLS && off < CELL_END) begin
               if (cur.cells_active) begin
                  if (w16 == 16'h0) begin
                     nxt.cells_active = 1'b0;
                  end else begin
                     emit             = 1'b1;
                     res.kind         = KIND_CELL;
                     res.item_index   = cur.cell_counter;
                     res.value        = {16'h0, w16};
                     nxt.cell_counter = cur.cell_counter + 5'd1;
                  end
               end
            end else if (off == OFF_PACKV + 9'd1) begin
               emit      = 1'b1;
               res.kind  = KIND_PACKV;
               res.value = {16'h0, w16};
            end else if (off == OFF_CURR + 9'd1) begin
               emit      = 1'b1;
               res.kind  = KIND_CURR;
               res.value = {{16{w16[15]}}, w16};
            end else if (off >= OFF_TEMP && off < OFF_TEMP + 9'd6) begin
               emit           = 1'b1;
               res.kind       = KIND_TEMP;
               res.item_index = temp_rel[5:1];
               res.value      = {16'h0, w16};
            end else if (off == OFF_CAP + 9'd3) begin
               emit      = 1'b1;
               res.kind  = KIND_CAP;
               res.value = w32;
            end
         end
         nxt.low_bytes = {data_byte, cur.low_bytes[23:8]};
         if (emit && (res.kind == KIND_DONE || res.kind == KIND_TRUNC)) begin
            nxt.in_frame    = 1'b0;
            nxt.sync_count  = 3'd0;
            nxt.byte_offset = '0;
         end else begin
            nxt.byte_offset = off + 9'd1;
         end
      end
   end

endmodule
